>>> rtl/vmft_pkg.sv
// Shared types and constants for the VLAN MAC forwarding table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package vmft_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int PORT_SLOTS    = 16;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int USED_W = $clog2(PORT_SLOTS + 1);

   localparam logic       MODE_ADD   = 1'b0;
   localparam logic       MODE_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_BAD  = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [11:0] vlan_id;
      logic [47:0] dest_mac;
      logic [15:0] port_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_port;
   } rsp_type;

   typedef struct packed {
      logic [11:0]       vlan;
      logic [47:0]       mac;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   typedef struct packed {
      logic load;
      logic slot_lookup;
      logic scan_rd;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_busy;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/vmft_ctrl.sv
// Sequencing state machine for the forwarding table.
// Depends on vmft_pkg; drives the datapath through command and status structs.
`default_nettype none

module vmft_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire vmft_pkg::sts_type sts,
   output vmft_pkg::cmd_type      cmd
);
   import vmft_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SLOT   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SLOT;
            end
         end
         S_SLOT:  state_in = S_SCAN;
         S_SCAN: begin
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_COMMIT;
         S_COMMIT: begin
            if (!sts.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign cmd.load        = (state_ff == S_IDLE) && req_valid;
   assign cmd.slot_lookup = (state_ff == S_SLOT);
   assign cmd.scan_rd     = (state_ff == S_SCAN);
   assign cmd.commit      = (state_ff == S_COMMIT) && !sts.out_busy;

endmodule

`default_nettype wire

>>> rtl/vmft_dpath.sv
// Datapath: entry memory, valid bits, port-slot table, scan compare and
// output register. Depends on vmft_pkg; sequenced by vmft_ctrl.
`default_nettype none

module vmft_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire vmft_pkg::cmd_type cmd,
   output vmft_pkg::sts_type      sts,
   input  wire vmft_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output vmft_pkg::rsp_type      rsp_data
);
   import vmft_pkg::*;

   entry_type         entry_mem [TABLE_ENTRIES];
   logic              valid_ff [TABLE_ENTRIES];
   logic [15:0]       slot_port_ff [PORT_SLOTS];
   logic [USED_W-1:0] slots_used_ff;

   req_type           item_ff;
   logic [IDX_W-1:0]  addr_ff;
   entry_type         rd_data_ff;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              stage_vld_ff;

   logic              slot_hit_ff, slot_hit_in;
   logic [SLOT_W-1:0] slot_idx_ff, slot_idx_in;
   logic              dup_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              best_found_ff;
   logic [SLOT_W-1:0] best_slot_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              key_match;
   logic              is_add;
   logic              full;
   logic              do_write;
   logic [SLOT_W-1:0] new_slot;

   always_comb begin
      slot_hit_in = 1'b0;
      slot_idx_in = '0;
      for (int s = PORT_SLOTS - 1; s >= 0; s--) begin
         if ((USED_W'(s) < slots_used_ff) && (slot_port_ff[s] == item_ff.port_id)) begin
            slot_hit_in = 1'b1;
            slot_idx_in = SLOT_W'(s);
         end
      end
   end

   assign key_match = (rd_data_ff.vlan == item_ff.vlan_id) &&
                      (rd_data_ff.mac == item_ff.dest_mac);
   assign is_add    = (item_ff.mode == MODE_ADD);
   assign full      = !free_found_ff ||
                      (!slot_hit_ff && (slots_used_ff == USED_W'(PORT_SLOTS)));
   assign do_write  = cmd.commit && is_add && !dup_ff && !full;
   assign new_slot  = slot_hit_ff ? slot_idx_ff : slots_used_ff[SLOT_W-1:0];

   always_comb begin
      rsp_in.status     = STATUS_OK;
      rsp_in.found_port = '0;
      if (is_add) begin
         if (!dup_ff && full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else if (best_found_ff) begin
         rsp_in.found_port = slot_port_ff[best_slot_ff];
      end else begin
         rsp_in.status = STATUS_MISS;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_mem[free_idx_ff] <= '{vlan: item_ff.vlan_id, mac: item_ff.dest_mac,
                                     slot: new_slot};
      end
      rd_data_ff <= entry_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         slots_used_ff <= '0;
         stage_vld_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (do_write) begin
            valid_ff[free_idx_ff] <= 1'b1;
            if (!slot_hit_ff) begin
               slots_used_ff <= slots_used_ff + 1'b1;
            end
         end
         stage_vld_ff <= cmd.scan_rd;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_write && !slot_hit_ff) begin
         slot_port_ff[slots_used_ff[SLOT_W-1:0]] <= item_ff.port_id;
      end
      if (cmd.load) begin
         item_ff       <= req_data;
         addr_ff       <= '0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end
      if (cmd.slot_lookup) begin
         slot_hit_ff <= slot_hit_in;
         slot_idx_ff <= slot_idx_in;
      end
      if (cmd.scan_rd) begin
         rd_valid_ff <= valid_ff[addr_ff];
         rd_idx_ff   <= addr_ff;
         addr_ff     <= addr_ff + 1'b1;
      end
      if (stage_vld_ff) begin
         if (rd_valid_ff) begin
            if (slot_hit_ff && (rd_data_ff.slot == slot_idx_ff) && key_match) begin
               dup_ff <= 1'b1;
            end
            if (key_match && (!best_found_ff || (rd_data_ff.slot < best_slot_ff))) begin
               best_found_ff <= 1'b1;
               best_slot_ff  <= rd_data_ff.slot;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= rd_idx_ff;
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.scan_last = (addr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sts.out_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/vlan_mac_forwarding_table_core.sv
// Top level of the VLAN MAC forwarding table.
// Depends on vmft_pkg, vmft_ctrl and vmft_dpath.
`default_nettype none

// The time from each add or query item's transfer to its result is set by the
// scan of the entry memory at one read per cycle; one item is in work at a time.
// A result waits in an output register, and the next request transfer is taken
// while it waits. The valid bits clear at reset, so no clearing pass is needed.
module vlan_mac_forwarding_table_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire vmft_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output vmft_pkg::rsp_type      rsp_data
);
   import vmft_pkg::*;

   cmd_type cmd;
   sts_type sts;

   vmft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vmft_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_commit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && !rsp_ready))
      else $error("A result was written over a pending transfer.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !cmd.commit))
      else $error("The block accepted or finished too early after a transfer.");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != STATUS_BAD))
      else $error("An undefined status code was returned.");

   a_port_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |-> (rsp_data.found_port == 16'd0))
      else $error("A failed result carried a nonzero port.");

endmodule

`default_nettype wire
